### hw/rtl/hvn_pkg.sv
// Package for the heightfield vertex normal block: grid sizes, fixed-point
// constants, operation codes and shared types. Depends on nothing.
`timescale 1ns / 1ps
package hvn_pkg;

  localparam int unsigned GridCols = 64;
  localparam int unsigned GridRows = 64;
  localparam int unsigned ColW     = 6;
  localparam int unsigned RowW     = 6;
  localparam int unsigned AddrW    = 12;
  localparam int unsigned HeightW  = 16;
  localparam int unsigned SizeW    = 7;
  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned NormW    = 16;

  // register indexes
  localparam logic [CfgIdxW-1:0] RegCols = 1'b0;
  localparam logic [CfgIdxW-1:0] RegRows = 1'b1;

  // operation codes
  localparam logic OpWrite = 1'b0;
  localparam logic OpRead  = 1'b1;

  // triangle sum accumulator width and root/divide widths
  localparam int unsigned AccW  = 24;
  localparam int unsigned RadW  = 64;
  localparam int unsigned RootW = 32;
  localparam int unsigned NumW  = 64;

  localparam logic signed [NormW-1:0] OutOne = 16'sd16384;

  // request to the shared root/divide unit
  typedef struct packed {
    logic             sqrt_start;
    logic             div_start;
    logic [RadW-1:0]  radicand;
    logic [NumW-1:0]  numer;
    logic [RootW-1:0] denom;
  } mu_req_t;

  typedef struct packed {
    logic             done;
    logic [RootW-1:0] root;
    logic [NumW-1:0]  quot;
  } mu_rsp_t;

endpackage

### hw/rtl/hvn_math_unit.sv
// Shared iterative unit for hvn: integer square root (two bits a step) and
// unsigned restoring division with round-to-nearest. Depends on hvn_pkg.
`timescale 1ns / 1ps
module hvn_math_unit (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  hvn_pkg::mu_req_t req_i,
  output hvn_pkg::mu_rsp_t rsp_o
);

  localparam logic [1:0] MuIdle = 2'd0;
  localparam logic [1:0] MuSqrt = 2'd1;
  localparam logic [1:0] MuDiv  = 2'd2;

  logic [1:0]                   state_q, state_d;
  logic [6:0]                   cnt_q, cnt_d;
  logic [hvn_pkg::RadW-1:0]     rem_q, rem_d;
  logic [hvn_pkg::RadW-1:0]     val_q, val_d;
  logic [hvn_pkg::RadW-1:0]     res_q, res_d;
  logic [hvn_pkg::RootW:0]      den_q, den_d;
  logic                         done_q, done_d;
  logic [hvn_pkg::RadW+1:0]     trial;
  logic [hvn_pkg::RadW:0]       drem;
  logic [hvn_pkg::RadW:0]       dsub;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    rem_d   = rem_q;
    val_d   = val_q;
    res_d   = res_q;
    den_d   = den_q;
    done_d  = 1'b0;
    trial   = '0;
    drem    = '0;
    dsub    = '0;
    unique case (state_q)
      MuIdle: begin
        if (req_i.sqrt_start) begin
          state_d = MuSqrt;
          cnt_d   = 7'd32;
          rem_d   = '0;
          val_d   = req_i.radicand;
          res_d   = '0;
        end else if (req_i.div_start) begin
          // rounded quotient (2n + d) / (2d): shift in 2n+d bits
          state_d = MuDiv;
          cnt_d   = 7'd64;
          rem_d   = '0;
          val_d   = (req_i.numer << 1) + {32'd0, req_i.denom};
          res_d   = '0;
          den_d   = {req_i.denom, 1'b0};
        end
      end
      MuSqrt: begin
        // bring down two bits, try root*4+1
        trial = {rem_q, val_q[hvn_pkg::RadW-1 -: 2]} - {res_q[hvn_pkg::RadW-1:0], 2'b01};
        if (!trial[hvn_pkg::RadW+1]) begin
          rem_d = trial[hvn_pkg::RadW-1:0];
          res_d = {res_q[hvn_pkg::RadW-2:0], 1'b1};
        end else begin
          rem_d = {rem_q[hvn_pkg::RadW-3:0], val_q[hvn_pkg::RadW-1 -: 2]};
          res_d = {res_q[hvn_pkg::RadW-2:0], 1'b0};
        end
        val_d = val_q << 2;
        cnt_d = cnt_q - 7'd1;
        if (cnt_q == 7'd1) begin
          state_d = MuIdle;
          done_d  = 1'b1;
        end
      end
      MuDiv: begin
        drem = {rem_q, val_q[hvn_pkg::RadW-1]};
        dsub = drem - {{(hvn_pkg::RadW-hvn_pkg::RootW){1'b0}}, den_q};
        if (!dsub[hvn_pkg::RadW]) begin
          rem_d = dsub[hvn_pkg::RadW-1:0];
          res_d = {res_q[hvn_pkg::RadW-2:0], 1'b1};
        end else begin
          rem_d = drem[hvn_pkg::RadW-1:0];
          res_d = {res_q[hvn_pkg::RadW-2:0], 1'b0};
        end
        val_d = val_q << 1;
        cnt_d = cnt_q - 7'd1;
        if (cnt_q == 7'd1) begin
          state_d = MuIdle;
          done_d  = 1'b1;
        end
      end
      default: state_d = MuIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= MuIdle;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    val_q <= val_d;
    res_q <= res_d;
    den_q <= den_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.root = res_q[hvn_pkg::RootW-1:0];
  assign rsp_o.quot = res_q;

endmodule

### hw/rtl/heightfield_vertex_normal.sv
// Top level of the heightfield vertex normal block: height store, sequencer
// and accumulators. Depends on hvn_pkg and hvn_math_unit.
`timescale 1ns / 1ps
// A write request, or any request outside the grid in use, passes through
// the StWrite and StOut states, and its result is then strobed. A read
// request first fetches all nine neighbouring heights from a store with a
// single read port, one a cycle. It then normalises each of the one to six
// triangles that touch the vertex, and finally their sum, through one shared
// unit: a square root and three divisions per vector. busy is high from the
// accepting edge until the result is strobed. The strobe is done_o, high
// for one cycle with busy already low, so a new request can be taken in
// that same cycle. After reset the store is cleared to zero, during which
// busy is high and no request is taken. The receiver cannot stall a result.
module heightfield_vertex_normal (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start,
  output logic                               busy,
  output logic                               done_o,
  input  logic                               cfg_we_i,
  input  logic [hvn_pkg::CfgIdxW-1:0]        cfg_idx_i,
  input  logic [hvn_pkg::SizeW-1:0]          cfg_data_i,
  input  logic                               operation_i,
  input  logic [hvn_pkg::ColW-1:0]           col_i,
  input  logic [hvn_pkg::RowW-1:0]           row_i,
  input  logic signed [hvn_pkg::HeightW-1:0] height_i,
  output logic signed [hvn_pkg::NormW-1:0]   normal_x_o,
  output logic signed [hvn_pkg::NormW-1:0]   normal_y_o,
  output logic signed [hvn_pkg::NormW-1:0]   normal_z_o,
  output logic                               out_of_range_o
);

  localparam logic [3:0] StClear = 4'd0;
  localparam logic [3:0] StIdle  = 4'd1;
  localparam logic [3:0] StFetch = 4'd2;
  localparam logic [3:0] StTri   = 4'd3;
  localparam logic [3:0] StTSqrt = 4'd4;
  localparam logic [3:0] StTDiv  = 4'd5;
  localparam logic [3:0] StNSqrt = 4'd6;
  localparam logic [3:0] StNDiv  = 4'd7;
  localparam logic [3:0] StOut   = 4'd8;
  localparam logic [3:0] StWrite = 4'd9;

  // configuration
  logic [hvn_pkg::SizeW-1:0] cols_q, rows_q;
  logic [hvn_pkg::SizeW-1:0] ncols, nrows;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cols_q <= hvn_pkg::SizeW'(hvn_pkg::GridCols);
      rows_q <= hvn_pkg::SizeW'(hvn_pkg::GridRows);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        hvn_pkg::RegCols: cols_q <= cfg_data_i;
        hvn_pkg::RegRows: rows_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // clamp sizes into the legal range
  always_comb begin
    ncols = (cols_q < 7'd2) ? 7'd2 :
            (cols_q > hvn_pkg::SizeW'(hvn_pkg::GridCols)) ?
            hvn_pkg::SizeW'(hvn_pkg::GridCols) : cols_q;
    nrows = (rows_q < 7'd2) ? 7'd2 :
            (rows_q > hvn_pkg::SizeW'(hvn_pkg::GridRows)) ?
            hvn_pkg::SizeW'(hvn_pkg::GridRows) : rows_q;
  end

  // height store
  logic [hvn_pkg::HeightW-1:0] mem [hvn_pkg::GridCols*hvn_pkg::GridRows];
  logic                        mem_we;
  logic [hvn_pkg::AddrW-1:0]   mem_waddr, mem_raddr;
  logic [hvn_pkg::HeightW-1:0] mem_wdata, mem_rdata_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    mem_rdata_q <= mem[mem_raddr];
  end

  // sequencer state
  logic [3:0]                  state_q, state_d;
  logic [hvn_pkg::AddrW-1:0]   clr_q, clr_d;
  logic                        op_q, op_d;
  logic [hvn_pkg::ColW-1:0]    col_q, col_d;
  logic [hvn_pkg::RowW-1:0]    row_q, row_d;
  logic [hvn_pkg::HeightW-1:0] hin_q, hin_d;
  logic [3:0]                  fidx_q, fidx_d;
  logic                        fval_q, fval_d;
  logic [3:0]                  fidx2_q, fidx2_d;
  logic signed [hvn_pkg::HeightW-1:0] nb_q [9];
  logic [2:0]                  tri_q, tri_d;
  logic [1:0]                  comp_q, comp_d;
  logic signed [17:0]          px_q, px_d, pz_q, pz_d;
  logic [hvn_pkg::RootW-1:0]   s_q, s_d;
  logic signed [hvn_pkg::AccW-1:0] acc_q [3];
  logic signed [hvn_pkg::AccW-1:0] acc_d [3];
  logic signed [hvn_pkg::NormW-1:0] res_q [3];
  logic signed [hvn_pkg::NormW-1:0] res_d [3];
  logic                        mu_wait_q, mu_wait_d;
  logic                        oor_q, oor_d;
  logic                        done_q, done_d;

  hvn_pkg::mu_req_t mu_req;
  hvn_pkg::mu_rsp_t mu_rsp;

  hvn_math_unit u_math (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mu_req),
    .rsp_o  (mu_rsp)
  );

  // neighbourhood position of fetch slot: dr = idx/3 - 1, dc = idx%3 - 1
  logic signed [7:0] f_r, f_c;
  logic [1:0]        f_dr, f_dc;
  always_comb begin
    unique case (fidx_q) inside
      4'd0, 4'd1, 4'd2: f_dr = 2'd0;
      4'd3, 4'd4, 4'd5: f_dr = 2'd1;
      default:          f_dr = 2'd2;
    endcase
    unique case (fidx_q) inside
      4'd0, 4'd3, 4'd6: f_dc = 2'd0;
      4'd1, 4'd4, 4'd7: f_dc = 2'd1;
      default:          f_dc = 2'd2;
    endcase
    f_r = $signed({2'b00, row_q}) + $signed({6'd0, f_dr}) - 8'sd1;
    f_c = $signed({2'b00, col_q}) + $signed({6'd0, f_dc}) - 8'sd1;
  end

  // triangle list: 0 A(r,c) 1 A(r,c-1) 2 B(r,c-1) 3 A(r-1,c) 4 B(r-1,c) 5 B(r-1,c-1)
  logic has_r, has_l, has_d, has_u;
  logic tri_ok;
  assign has_r = ({1'b0, col_q} + 7'd1) < ncols;
  assign has_d = ({1'b0, row_q} + 7'd1) < nrows;
  assign has_l = col_q != '0;
  assign has_u = row_q != '0;
  always_comb begin
    case (tri_q) inside
      3'd0:       tri_ok = has_r && has_d;
      3'd1, 3'd2: tri_ok = has_l && has_d;
      3'd3, 3'd4: tri_ok = has_u && has_r;
      3'd5:       tri_ok = has_u && has_l;
      default:    tri_ok = 1'b0;
    endcase
  end

  // neighbour heights: nb index = (dr+1)*3 + (dc+1)
  logic signed [17:0] tpx, tpz;
  function automatic logic signed [17:0] hd(input logic signed [15:0] a,
                                            input logic signed [15:0] b);
    hd = 18'(a) - 18'(b);
  endfunction
  always_comb begin
    tpx = '0;
    tpz = '0;
    case (tri_q)
      3'd0: begin tpx = hd(nb_q[4], nb_q[5]); tpz = hd(nb_q[4], nb_q[7]); end
      3'd1: begin tpx = hd(nb_q[3], nb_q[4]); tpz = hd(nb_q[3], nb_q[6]); end
      3'd2: begin tpx = hd(nb_q[6], nb_q[7]); tpz = hd(nb_q[4], nb_q[7]); end
      3'd3: begin tpx = hd(nb_q[1], nb_q[2]); tpz = hd(nb_q[1], nb_q[4]); end
      3'd4: begin tpx = hd(nb_q[4], nb_q[5]); tpz = hd(nb_q[2], nb_q[5]); end
      3'd5: begin tpx = hd(nb_q[3], nb_q[4]); tpz = hd(nb_q[1], nb_q[4]); end
      default: ;
    endcase
  end

  // current component value for division
  logic signed [hvn_pkg::AccW-1:0] cur_t, cur_n;
  logic [hvn_pkg::AccW-1:0]        mag_t, mag_n;
  always_comb begin
    case (comp_q)
      2'd0:    cur_t = hvn_pkg::AccW'(px_q);
      2'd1:    cur_t = hvn_pkg::AccW'(18'sd256);
      default: cur_t = hvn_pkg::AccW'(pz_q);
    endcase
    case (comp_q)
      2'd0:    cur_n = acc_q[0];
      2'd1:    cur_n = acc_q[1];
      default: cur_n = acc_q[2];
    endcase
    mag_t = cur_t[hvn_pkg::AccW-1] ? hvn_pkg::AccW'(-cur_t) : cur_t;
    mag_n = cur_n[hvn_pkg::AccW-1] ? hvn_pkg::AccW'(-cur_n) : cur_n;
  end

  // squared length products, one square per component
  logic [35:0] sq_px, sq_pz;
  logic [47:0] sq_a0, sq_a1, sq_a2;
  logic [17:0] apx, apz;
  assign apx   = px_q[17] ? 18'(-px_q) : px_q;
  assign apz   = pz_q[17] ? 18'(-pz_q) : pz_q;
  assign sq_px = apx * apx;
  assign sq_pz = apz * apz;
  logic [23:0] aa0, aa1, aa2;
  assign aa0 = acc_q[0][hvn_pkg::AccW-1] ? 24'(-acc_q[0]) : acc_q[0];
  assign aa1 = acc_q[1][hvn_pkg::AccW-1] ? 24'(-acc_q[1]) : acc_q[1];
  assign aa2 = acc_q[2][hvn_pkg::AccW-1] ? 24'(-acc_q[2]) : acc_q[2];
  assign sq_a0 = aa0 * aa0;
  assign sq_a1 = aa1 * aa1;
  assign sq_a2 = aa2 * aa2;

  logic [hvn_pkg::NumW-1:0] qsig;
  logic signed [hvn_pkg::NumW-1:0] qval;
  logic signed [hvn_pkg::NormW-1:0] qclamp;

  always_comb begin
    state_d   = state_q;
    clr_d     = clr_q;
    op_d      = op_q;
    col_d     = col_q;
    row_d     = row_q;
    hin_d     = hin_q;
    fidx_d    = fidx_q;
    fval_d    = 1'b0;
    fidx2_d   = fidx_q;
    tri_d     = tri_q;
    comp_d    = comp_q;
    px_d      = px_q;
    pz_d      = pz_q;
    s_d       = s_q;
    acc_d     = acc_q;
    res_d     = res_q;
    mu_wait_d = mu_wait_q;
    oor_d     = oor_q;
    done_d    = 1'b0;
    mem_we    = 1'b0;
    mem_waddr = clr_q;
    mem_wdata = '0;
    mem_raddr = {f_r[5:0], f_c[5:0]};
    mu_req    = '0;
    qval      = '0;
    qsig      = mu_rsp.quot;
    qclamp    = '0;

    unique case (state_q)
      StClear: begin
        // sweep the store to zero after reset
        mem_we = 1'b1;
        clr_d  = clr_q + hvn_pkg::AddrW'(1);
        if (clr_q == '1) state_d = StIdle;
      end
      StIdle: begin
        if (start) begin
          op_d  = operation_i;
          col_d = col_i;
          row_d = row_i;
          hin_d = height_i;
          oor_d = ({1'b0, col_i} >= ncols) || ({1'b0, row_i} >= nrows);
          res_d[0] = '0; res_d[1] = '0; res_d[2] = '0;
          acc_d[0] = '0; acc_d[1] = '0; acc_d[2] = '0;
          fidx_d = '0;
          tri_d  = '0;
          state_d = StWrite;
        end
      end
      StWrite: begin
        if (oor_q) begin
          state_d = StOut;
        end else if (op_q == hvn_pkg::OpWrite) begin
          mem_we    = 1'b1;
          mem_waddr = {row_q, col_q};
          mem_wdata = hin_q;
          state_d   = StOut;
        end else begin
          state_d = StFetch;
        end
      end
      StFetch: begin
        // one read per cycle; slots off the grid are never used
        fval_d  = 1'b1;
        fidx2_d = fidx_q;
        fidx_d  = fidx_q + 4'd1;
        if (fidx_q == 4'd8) state_d = StTri;
      end
      StTri: begin
        if (fval_q) begin
          // last read still landing
        end else if (tri_q == 3'd6) begin
          state_d   = StNSqrt;
          mu_wait_d = 1'b0;
        end else if (tri_ok) begin
          px_d      = tpx;
          pz_d      = tpz;
          state_d   = StTSqrt;
          mu_wait_d = 1'b0;
        end else begin
          tri_d = tri_q + 3'd1;
        end
      end
      StTSqrt: begin
        if (!mu_wait_q) begin
          mu_req.sqrt_start = 1'b1;
          mu_req.radicand   = 64'(36'(sq_px) + 36'(sq_pz) + 36'd65536) << 30;
          mu_wait_d = 1'b1;
        end else if (mu_rsp.done) begin
          s_d       = (mu_rsp.root == '0) ? 32'd1 : mu_rsp.root;
          comp_d    = '0;
          mu_wait_d = 1'b0;
          state_d   = StTDiv;
        end
      end
      StTDiv: begin
        if (!mu_wait_q) begin
          mu_req.div_start = 1'b1;
          mu_req.numer     = 64'(mag_t) << 35;
          mu_req.denom     = s_q;
          mu_wait_d = 1'b1;
        end else if (mu_rsp.done) begin
          qval = cur_t[hvn_pkg::AccW-1] ? -$signed(qsig) : $signed(qsig);
          unique case (comp_q)
            2'd0:    acc_d[0] = acc_q[0] + hvn_pkg::AccW'(qval);
            2'd1:    acc_d[1] = acc_q[1] + hvn_pkg::AccW'(qval);
            default: acc_d[2] = acc_q[2] + hvn_pkg::AccW'(qval);
          endcase
          mu_wait_d = 1'b0;
          if (comp_q == 2'd2) begin
            tri_d   = tri_q + 3'd1;
            state_d = StTri;
          end else begin
            comp_d = comp_q + 2'd1;
          end
        end
      end
      StNSqrt: begin
        if (!mu_wait_q) begin
          mu_req.sqrt_start = 1'b1;
          mu_req.radicand   = (64'(sq_a0) + 64'(sq_a1) + 64'(sq_a2)) << 16;
          mu_wait_d = 1'b1;
        end else if (mu_rsp.done) begin
          s_d       = (mu_rsp.root == '0) ? 32'd1 : mu_rsp.root;
          comp_d    = '0;
          mu_wait_d = 1'b0;
          state_d   = StNDiv;
        end
      end
      StNDiv: begin
        if (!mu_wait_q) begin
          mu_req.div_start = 1'b1;
          mu_req.numer     = 64'(mag_n) << 22;
          mu_req.denom     = s_q;
          mu_wait_d = 1'b1;
        end else if (mu_rsp.done) begin
          qclamp = (qsig > 64'd16384) ? hvn_pkg::OutOne : 16'(qsig);
          if (cur_n[hvn_pkg::AccW-1]) qclamp = -qclamp;
          unique case (comp_q)
            2'd0:    res_d[0] = qclamp;
            2'd1:    res_d[1] = qclamp;
            default: res_d[2] = qclamp;
          endcase
          mu_wait_d = 1'b0;
          if (comp_q == 2'd2) begin
            state_d = StOut;
          end else begin
            comp_d = comp_q + 2'd1;
          end
        end
      end
      StOut: begin
        done_d  = 1'b1;
        state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StClear;
      clr_q     <= '0;
      fval_q    <= 1'b0;
      mu_wait_q <= 1'b0;
      done_q    <= 1'b0;
    end else begin
      state_q   <= state_d;
      clr_q     <= clr_d;
      fval_q    <= fval_d;
      mu_wait_q <= mu_wait_d;
      done_q    <= done_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    op_q    <= op_d;
    col_q   <= col_d;
    row_q   <= row_d;
    hin_q   <= hin_d;
    fidx_q  <= fidx_d;
    fidx2_q <= fidx2_d;
    tri_q   <= tri_d;
    comp_q  <= comp_d;
    px_q    <= px_d;
    pz_q    <= pz_d;
    s_q     <= s_d;
    acc_q   <= acc_d;
    res_q   <= res_d;
    oor_q   <= oor_d;
    if (fval_q) nb_q[fidx2_q] <= mem_rdata_q;
  end

  assign busy           = state_q != StIdle;
  assign done_o         = done_q;
  assign normal_x_o     = res_q[0];
  assign normal_y_o     = res_q[1];
  assign normal_z_o     = res_q[2];
  assign out_of_range_o = oor_q;

endmodule
